@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/rwhp_pkg.sv @@
// Package: types and constants of the RIFF/WAVE header parser
`default_nettype none
package rwhp_pkg;
    localparam int POS_WIDTH_DEF = 40;
    localparam int OFF_W = 40;

    localparam logic [3:0] ST_OK = 4'd0;
    localparam logic [3:0] ST_MAGIC = 4'd1;
    localparam logic [3:0] ST_FMT_SIZE = 4'd2;
    localparam logic [3:0] ST_FMT_TRUNC = 4'd3;
    localparam logic [3:0] ST_MISSING = 4'd4;
    localparam logic [3:0] ST_FORMAT = 4'd5;
    localparam logic [3:0] ST_CHAN_RATE = 4'd6;
    localparam logic [3:0] ST_DEPTH = 4'd7;
    localparam logic [3:0] ST_FLOAT = 4'd8;
    localparam logic [3:0] ST_ALIGN = 4'd9;
    localparam logic [3:0] ST_NO_FRAMES = 4'd10;

    localparam logic [31:0] TAG_FMT = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;
    localparam logic [31:0] MAGIC_RIFF = 32'h52494646;
    localparam logic [31:0] MAGIC_WAVE = 32'h57415645;
    localparam logic [15:0] TAG_EXT = 16'hFFFE;
    localparam logic [31:0] FMT_MAX = 32'd4096;
    localparam logic [31:0] FMT_MIN = 32'd16;
    localparam logic [31:0] EXT_MIN = 32'd40;
    localparam logic [31:0] RATE_MAX = 32'd384000;
    localparam logic [31:0] RATE_MIN = 32'd8000;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       first;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] frame_bytes;
        logic [15:0] sample_bits;
        logic [31:0] payload_bytes;
        logic [39:0] payload_offset;
        logic [31:0] frame_total;
    } out_beat_t;

    // front-to-back job: a finished header, with checks to run
    typedef struct packed {
        logic        need_div;
        logic [3:0]  status;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] frame_bytes;
        logic [15:0] sample_bits;
        logic [31:0] payload_bytes;
        logic [39:0] payload_offset;
    } job_t;
endpackage
`default_nettype wire

@@ sv/rwhp_front.sv @@
// Front end: byte-serial chunk walker that captures fmt fields and raises jobs
`default_nettype none
module rwhp_front #(
    parameter int POS_WIDTH = rwhp_pkg::POS_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rwhp_pkg::in_beat_t in_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output rwhp_pkg::job_t        job,
    output logic                  job_valid,
    input  wire logic             job_ready
);
    localparam logic [2:0] PH_RIFF = 3'd0;
    localparam logic [2:0] PH_HDR = 3'd1;
    localparam logic [2:0] PH_FMT = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_PAD = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;
    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    logic [2:0] phase_reg, phase_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [31:0] cnt_reg, cnt_next, tag_reg, tag_next, len_reg, len_next;
    logic [15:0] ftag_reg, ftag_next, chan_reg, chan_next, align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] rate_reg, rate_next;
    logic fseen_reg, fseen_next, magic_reg, magic_next;
    logic emit;
    rwhp_pkg::job_t jb;

    logic [2:0] ph;
    logic [POS_WIDTH-1:0] pos;
    logic [31:0] n, tg, ln, rt;
    logic [15:0] ft, ch, al, bt;
    logic fs, mg;
    logic [7:0] b;
    logic [32:0] n1;

    assign in_ready = job_ready;
    assign b = in_data.byte_in;

    always_comb
    begin
        ph = phase_reg; pos = pos_reg; n = cnt_reg; tg = tag_reg; ln = len_reg;
        ft = ftag_reg; ch = chan_reg; rt = rate_reg; al = align_reg; bt = bits_reg;
        fs = fseen_reg; mg = magic_reg;
        if (in_data.first)
        begin
            ph = PH_RIFF; pos = '0; n = '0; tg = '0; ln = '0; ft = '0; ch = '0;
            rt = '0; al = '0; bt = '0; fs = 1'b0; mg = 1'b1;
        end
        emit = 1'b0;
        jb = '0;
        n1 = {1'b0, n} + 33'd1;
        if (ph != PH_DONE)
        begin
            if (pos != POS_MAX)
                pos = pos + 1'b1;
            unique case (ph)
                PH_RIFF:
                begin
                    if (n < 32'd4 && b != rwhp_pkg::MAGIC_RIFF[8*(3-n[1:0]) +: 8])
                        mg = 1'b0;
                    if (n >= 32'd8 && n < 32'd12
                        && b != rwhp_pkg::MAGIC_WAVE[8*(3-n[1:0]) +: 8])
                        mg = 1'b0;
                    n = n1[31:0];
                    if (n1 >= 33'd12)
                    begin
                        n = '0;
                        if (!mg)
                        begin
                            emit = 1'b1; jb.status = rwhp_pkg::ST_MAGIC; ph = PH_DONE;
                        end
                        else
                            ph = PH_HDR;
                    end
                end
                PH_HDR:
                begin
                    if (n < 32'd4)
                        tg = {tg[23:0], b};
                    else
                        ln[8*n[1:0] +: 8] = b;
                    n = n1[31:0];
                    if (n1 >= 33'd8)
                    begin
                        n = '0;
                        if (tg == rwhp_pkg::TAG_FMT)
                        begin
                            if (ln < rwhp_pkg::FMT_MIN || ln > rwhp_pkg::FMT_MAX)
                            begin
                                emit = 1'b1; jb.status = rwhp_pkg::ST_FMT_SIZE;
                                ph = PH_DONE;
                            end
                            else
                                ph = PH_FMT;
                        end
                        else if (tg == rwhp_pkg::TAG_DATA)
                        begin
                            emit = 1'b1; jb.need_div = 1'b1; ph = PH_DONE;
                            jb.payload_bytes = ln;
                            jb.payload_offset = 40'(pos);
                        end
                        else
                            ph = (ln == '0) ? PH_HDR : PH_SKIP;
                    end
                end
                PH_FMT:
                begin
                    if (n < 32'd2) ft[8*n[0] +: 8] = b;
                    else if (n < 32'd4) ch[8*n[0] +: 8] = b;
                    else if (n < 32'd8) rt[8*n[1:0] +: 8] = b;
                    else if (n >= 32'd12 && n < 32'd14) al[8*n[0] +: 8] = b;
                    else if (n >= 32'd14 && n < 32'd16) bt[8*n[0] +: 8] = b;
                    else if (n == 32'd25 && ft == rwhp_pkg::TAG_EXT
                             && ln >= rwhp_pkg::EXT_MIN)
                        ft = {b, tg[7:0]};
                    tg = {tg[23:0], b};
                    n = n1[31:0];
                    if (n1 >= {1'b0, ln})
                    begin
                        fs = 1'b1; n = '0; ph = ln[0] ? PH_PAD : PH_HDR;
                    end
                end
                PH_SKIP:
                begin
                    n = n1[31:0];
                    if (n1 >= {1'b0, ln})
                    begin
                        n = '0; ph = ln[0] ? PH_PAD : PH_HDR;
                    end
                end
                default:
                begin
                    n = '0; ph = PH_HDR;
                end
            endcase
            if (in_data.last && !emit && ph != PH_DONE)
            begin
                emit = 1'b1;
                jb.status = (ph == PH_RIFF) ? rwhp_pkg::ST_MAGIC :
                            (ph == PH_FMT) ? rwhp_pkg::ST_FMT_TRUNC : rwhp_pkg::ST_MISSING;
                ph = PH_DONE;
            end
        end
        if (!fs && jb.need_div)
        begin
            jb.need_div = 1'b0; jb.status = rwhp_pkg::ST_MISSING;
        end
        jb.format_tag = ft; jb.channel_count = ch; jb.rate_hz = rt;
        jb.frame_bytes = al; jb.sample_bits = bt;
        phase_next = ph; pos_next = pos; cnt_next = n; tag_next = tg; len_next = ln;
        ftag_next = ft; chan_next = ch; rate_next = rt; align_next = al;
        bits_next = bt; fseen_next = fs; magic_next = mg;
    end

    assign job = jb;
    assign job_valid = in_valid && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF; pos_reg <= '0; cnt_reg <= '0; tag_reg <= '0;
            len_reg <= '0; ftag_reg <= '0; chan_reg <= '0; rate_reg <= '0;
            align_reg <= '0; bits_reg <= '0; fseen_reg <= 1'b0; magic_reg <= 1'b1;
        end
        else if (in_valid && in_ready)
        begin
            phase_reg <= phase_next; pos_reg <= pos_next; cnt_reg <= cnt_next;
            tag_reg <= tag_next; len_reg <= len_next; ftag_reg <= ftag_next;
            chan_reg <= chan_next; rate_reg <= rate_next; align_reg <= align_next;
            bits_reg <= bits_next; fseen_reg <= fseen_next; magic_reg <= magic_next;
        end
    end
endmodule
`default_nettype wire

@@ sv/rwhp_queue.sv @@
// Two-entry job queue between front and back
`default_nettype none
module rwhp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rwhp_pkg::job_t wr_data,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    output rwhp_pkg::job_t      rd_data,
    output logic                rd_valid,
    input  wire logic           rd_ready
);
    rwhp_pkg::job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

@@ sv/rwhp_back.sv @@
// Back end: field checks and iterative frame-count division
`default_nettype none
module rwhp_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rwhp_pkg::job_t  job,
    input  wire logic            job_valid,
    output logic                 job_ready,
    output rwhp_pkg::out_beat_t  out_data,
    output logic                 out_valid,
    input  wire logic            out_ready
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV = 2'd1;
    localparam logic [1:0] S_OUT = 2'd2;

    logic [1:0] state_reg;
    logic [5:0] step_reg;
    logic [31:0] quo_reg, rem_reg;
    logic [32:0] trial;
    rwhp_pkg::out_beat_t res_reg;
    logic [3:0] chk;
    logic [18:0] need;
    logic [13:0] bytes_ps;

    assign job_ready = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign out_data = res_reg;

    always_comb
    begin
        bytes_ps = {1'b0, job.sample_bits[15:3]} + {13'd0, |job.sample_bits[2:0]};
        need = 19'(job.channel_count[3:0]) * 19'(bytes_ps);
        if (job.format_tag != 16'd1 && job.format_tag != 16'd3)
            chk = rwhp_pkg::ST_FORMAT;
        else if (job.channel_count < 16'd1 || job.channel_count > 16'd8
                 || job.rate_hz < rwhp_pkg::RATE_MIN || job.rate_hz > rwhp_pkg::RATE_MAX)
            chk = rwhp_pkg::ST_CHAN_RATE;
        else if (job.sample_bits != 16'd8 && job.sample_bits != 16'd16
                 && job.sample_bits != 16'd24 && job.sample_bits != 16'd32)
            chk = rwhp_pkg::ST_DEPTH;
        else if (job.format_tag == 16'd3 && job.sample_bits != 16'd32)
            chk = rwhp_pkg::ST_FLOAT;
        else if (job.frame_bytes == 16'd0 || {3'd0, job.frame_bytes} < need)
            chk = rwhp_pkg::ST_ALIGN;
        else
            chk = rwhp_pkg::ST_OK;
        trial = {rem_reg, quo_reg[31]} - {17'd0, res_reg.frame_bytes};
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && job_valid)
        begin
            res_reg.status <= job.need_div ? chk : job.status;
            res_reg.format_tag <= job.format_tag;
            res_reg.channel_count <= job.channel_count;
            res_reg.rate_hz <= job.rate_hz;
            res_reg.frame_bytes <= job.frame_bytes;
            res_reg.sample_bits <= job.sample_bits;
            res_reg.payload_bytes <= job.payload_bytes;
            res_reg.payload_offset <= job.payload_offset;
            res_reg.frame_total <= '0;
            quo_reg <= job.payload_bytes;
            rem_reg <= '0;
            step_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            step_reg <= step_reg + 6'd1;
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
            if (step_reg == 6'd32)
            begin
                res_reg.frame_total <= quo_reg;
                if (quo_reg == '0)
                    res_reg.status <= rwhp_pkg::ST_NO_FRAMES;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (job_valid)
                        state_reg <= (job.need_div && chk == rwhp_pkg::ST_OK) ? S_DIV : S_OUT;
                S_DIV:
                    if (step_reg == 6'd32)
                        state_reg <= S_OUT;
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ sv/riff_wave_header_parser.sv @@
// Top level of the RIFF/WAVE header parser
`default_nettype none
// Takes one file byte per beat and emits one result beat per file. Header
// bytes are taken one per cycle; the front end stalls only while the
// two-entry job queue is full. A data chunk header with valid fields starts
// a shift-subtract divider for the frame count; other results skip the
// divider and go straight from the job queue to the result register.
module riff_wave_header_parser #(
    parameter int POS_WIDTH = rwhp_pkg::POS_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rwhp_pkg::in_beat_t   in_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output rwhp_pkg::out_beat_t       out_data,
    output logic                      out_valid,
    input  wire logic                 out_ready
);
    rwhp_pkg::job_t fq_data, qb_data;
    logic fq_valid, fq_ready, qb_valid, qb_ready;

    rwhp_front #(.POS_WIDTH(POS_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .in_valid(in_valid),
        .in_ready(in_ready), .job(fq_data), .job_valid(fq_valid), .job_ready(fq_ready)
    );

    rwhp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_data(fq_data), .wr_valid(fq_valid),
        .wr_ready(fq_ready), .rd_data(qb_data), .rd_valid(qb_valid), .rd_ready(qb_ready)
    );

    rwhp_back u_back (
        .clk(clk), .rst_n(rst_n), .job(qb_data), .job_valid(qb_valid),
        .job_ready(qb_ready), .out_data(out_data), .out_valid(out_valid),
        .out_ready(out_ready)
    );
endmodule
`default_nettype wire

@@ sv/rwhp_checker.sv @@
// Port-level assertions for the header parser, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module rwhp_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire rwhp_pkg::in_beat_t  in_data,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire rwhp_pkg::out_beat_t out_data,
    input wire logic                out_valid,
    input wire logic                out_ready
);
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result beat dropped or changed while stalled")
    `CHK_IMPL(a_status_range, clk, rst_n, out_valid, out_data.status <= rwhp_pkg::ST_NO_FRAMES, "status code out of range")
    `CHK_IMPL(a_frames_ok, clk, rst_n, out_valid && out_data.status != rwhp_pkg::ST_OK && out_data.status != rwhp_pkg::ST_NO_FRAMES, out_data.frame_total == '0, "frame count on failed header")
    `CHK_IMPL(a_no_frames, clk, rst_n, out_valid && out_data.status == rwhp_pkg::ST_NO_FRAMES, out_data.frame_total == '0, "no-frames status with frames")
endmodule
bind riff_wave_header_parser rwhp_checker u_rwhp_checker (.*);
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for riff_wave_header_parser: random and directed WAV streams against a scoreboard
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = 40;
    localparam logic [2:0] PH_RIFF = 3'd0, PH_HDR = 3'd1, PH_FMT = 3'd2,
                           PH_SKIP = 3'd3, PH_PAD = 3'd4, PH_DONE = 3'd5;

    class wav_scoreboard;
        logic [2:0] phase;
        logic [PW-1:0] pos;
        logic [31:0] cnt, shreg, clen, rate;
        logic [15:0] ftag, chan, align, bits;
        bit fmt_seen, magic_ok;
        rwhp_pkg::out_beat_t pending[$];
        int errors;

        function void clear();
            phase = PH_RIFF; pos = '0; cnt = 0; shreg = 0; clen = 0; rate = 0;
            ftag = 0; chan = 0; align = 0; bits = 0; fmt_seen = 0; magic_ok = 1;
        endfunction

        function rwhp_pkg::out_beat_t header_result(logic [3:0] st);
            rwhp_pkg::out_beat_t r;
            r = '0;
            r.status = st; r.format_tag = ftag; r.channel_count = chan;
            r.rate_hz = rate; r.frame_bytes = align; r.sample_bits = bits;
            return r;
        endfunction

        function rwhp_pkg::out_beat_t data_result();
            rwhp_pkg::out_beat_t r;
            logic [3:0] st;
            logic [31:0] need, frames;
            need = chan * ((32'(bits) + 7) / 8);
            frames = 0;
            if (!fmt_seen) st = rwhp_pkg::ST_MISSING;
            else if (ftag != 1 && ftag != 3) st = rwhp_pkg::ST_FORMAT;
            else if (chan < 1 || chan > 8 || rate < rwhp_pkg::RATE_MIN
                     || rate > rwhp_pkg::RATE_MAX)
                st = rwhp_pkg::ST_CHAN_RATE;
            else if (!(bits inside {16'd8, 16'd16, 16'd24, 16'd32})) st = rwhp_pkg::ST_DEPTH;
            else if (ftag == 3 && bits != 32) st = rwhp_pkg::ST_FLOAT;
            else if (align == 0 || 32'(align) < need) st = rwhp_pkg::ST_ALIGN;
            else
            begin
                frames = clen / align;
                st = (frames != 0) ? rwhp_pkg::ST_OK : rwhp_pkg::ST_NO_FRAMES;
            end
            r = header_result(st);
            r.payload_bytes = clen;
            r.payload_offset = pos[39:0];
            r.frame_total = frames;
            return r;
        endfunction

        function void end_body();
            cnt = 0;
            phase = clen[0] ? PH_PAD : PH_HDR;
        endfunction

        function void note_input(rwhp_pkg::in_beat_t ib);
            logic [7:0] b;
            logic [31:0] n;
            bit got;
            b = ib.byte_in;
            got = 0;
            if (ib.first) clear();
            if (phase == PH_DONE) return;
            n = cnt;
            if (pos != {PW{1'b1}}) pos++;
            case (phase)
                PH_RIFF:
                begin
                    if (n < 4 && b != rwhp_pkg::MAGIC_RIFF[31-8*n -: 8]) magic_ok = 0;
                    if (n >= 8 && n < 12 && b != rwhp_pkg::MAGIC_WAVE[31-8*(n-8) -: 8])
                        magic_ok = 0;
                    cnt = n + 1;
                    if (n >= 11)
                    begin
                        cnt = 0;
                        if (!magic_ok)
                        begin
                            pending.push_back(header_result(rwhp_pkg::ST_MAGIC));
                            phase = PH_DONE; got = 1;
                        end
                        else phase = PH_HDR;
                    end
                end
                PH_HDR:
                begin
                    if (n < 4) shreg = {shreg[23:0], b};
                    else clen[8*(n-4) +: 8] = b;
                    cnt = n + 1;
                    if (n >= 7)
                    begin
                        cnt = 0;
                        if (shreg == rwhp_pkg::TAG_FMT)
                        begin
                            if (clen < rwhp_pkg::FMT_MIN || clen > rwhp_pkg::FMT_MAX)
                            begin
                                pending.push_back(header_result(rwhp_pkg::ST_FMT_SIZE));
                                phase = PH_DONE; got = 1;
                            end
                            else phase = PH_FMT;
                        end
                        else if (shreg == rwhp_pkg::TAG_DATA)
                        begin
                            pending.push_back(data_result());
                            phase = PH_DONE; got = 1;
                        end
                        else phase = (clen == 0) ? PH_HDR : PH_SKIP;
                    end
                end
                PH_FMT:
                begin
                    if (n < 2) ftag[8*n +: 8] = b;
                    else if (n < 4) chan[8*(n-2) +: 8] = b;
                    else if (n < 8) rate[8*(n-4) +: 8] = b;
                    else if (n >= 12 && n < 14) align[8*(n-12) +: 8] = b;
                    else if (n >= 14 && n < 16) bits[8*(n-14) +: 8] = b;
                    else if (n == 25 && ftag == rwhp_pkg::TAG_EXT && clen >= rwhp_pkg::EXT_MIN)
                        ftag = {b, shreg[7:0]};
                    shreg = {shreg[23:0], b};
                    cnt = n + 1;
                    if (cnt >= clen)
                    begin
                        fmt_seen = 1;
                        end_body();
                    end
                end
                PH_SKIP:
                begin
                    cnt = n + 1;
                    if (cnt >= clen) end_body();
                end
                default:
                begin
                    cnt = 0;
                    phase = PH_HDR;
                end
            endcase
            if (ib.last && !got && phase != PH_DONE)
            begin
                pending.push_back(header_result(phase == PH_RIFF ? rwhp_pkg::ST_MAGIC :
                    (phase == PH_FMT ? rwhp_pkg::ST_FMT_TRUNC : rwhp_pkg::ST_MISSING)));
                phase = PH_DONE;
            end
        endfunction

        function void check_result(rwhp_pkg::out_beat_t got);
            rwhp_pkg::out_beat_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                $display("%0t: result differs, expected %h, actual %h", $time, e, got);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
    rwhp_pkg::in_beat_t in_data;
    rwhp_pkg::out_beat_t out_data;
    wav_scoreboard sb;
    int send_idle, recv_stall, results_seen;
    byte unsigned file_bytes[$];

    riff_wave_header_parser dut (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .in_valid(in_valid),
        .in_ready(in_ready), .out_data(out_data), .out_valid(out_valid),
        .out_ready(out_ready)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("riff_wave_header_parser: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_result(out_data);
                results_seen++;
            end
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_beat(logic [7:0] b, logic f, logic l);
        rwhp_pkg::in_beat_t ib;
        ib.byte_in = b; ib.first = f; ib.last = l;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_data <= ib;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(ib);
    endtask

    task automatic idle_in();
        in_valid <= 0;
        @(posedge clk);
    endtask

    // send the byte queue as one file; last on its final byte when asked
    task automatic send_file(bit mark_last);
        for (int i = 0; i < file_bytes.size(); i++)
            send_beat(file_bytes[i], i == 0, mark_last && i == file_bytes.size() - 1);
        idle_in();
    endtask

    task automatic put32(logic [31:0] v, bit be);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(be ? v[31-8*i -: 8] : v[8*i +: 8]);
    endtask

    task automatic put16(logic [15:0] v);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
    endtask

    task automatic riff_head(bit bad);
        file_bytes = {};
        put32(rwhp_pkg::MAGIC_RIFF ^ (bad ? 32'h1 << $urandom_range(31) : 0), 1);
        put32($urandom, 0);
        put32(rwhp_pkg::MAGIC_WAVE, 1);
    endtask

    task automatic fmt_chunk(logic [31:0] sz, logic [15:0] tg, logic [15:0] ch,
                             logic [31:0] rt, logic [15:0] al, logic [15:0] bt,
                             logic [15:0] sub);
        put32(rwhp_pkg::TAG_FMT, 1);
        put32(sz, 0);
        for (int i = 0; i < sz; i++)
        begin
            case (i)
                0: put16(tg);
                2: put16(ch);
                4: put32(rt, 0);
                12: put16(al);
                14: put16(bt);
                24: put16(sub);
                default: ;
            endcase
            if (!(i inside {0, 2, 4, 12, 14, 24}) &&
                !(i inside {1, 3, 5, 6, 7, 13, 15, 25}))
                file_bytes.push_back($urandom);
        end
        if (sz[0]) file_bytes.push_back($urandom);
    endtask

    task automatic junk_chunk(logic [31:0] sz);
        put32($urandom, 1);
        put32(sz, 0);
        for (int i = 0; i < sz + sz[0]; i++) file_bytes.push_back($urandom);
    endtask

    task automatic data_head(logic [31:0] sz);
        put32(rwhp_pkg::TAG_DATA, 1);
        put32(sz, 0);
    endtask

    function automatic logic [15:0] pick_bits();
        case ($urandom_range(5))
            0: return 8;
            1: return 16;
            2: return 24;
            3: return 32;
            4: return $urandom_range(40);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_file();
        logic [15:0] tg, ch, al, bt;
        logic [31:0] rt, sz, dsz;
        int kind;
        kind = $urandom_range(99);
        riff_head(kind < 4);
        if ($urandom_range(3) == 0) junk_chunk($urandom_range(7));
        tg = ($urandom_range(9) < 6) ? 1 : ($urandom_range(2) == 0 ? rwhp_pkg::TAG_EXT :
             ($urandom_range(1) ? 3 : $urandom));
        ch = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 9);
        rt = ($urandom_range(7) == 0) ? $urandom : $urandom_range(7999, 384001);
        bt = pick_bits();
        al = ($urandom_range(4) == 0) ? $urandom_range(0, 70) :
             ch * ((bt + 7) / 8);
        sz = (tg == rwhp_pkg::TAG_EXT) ? $urandom_range(38, 44) : $urandom_range(16, 20);
        if (kind < 8) sz = $urandom_range(1) ? $urandom_range(0, 15) : 4097 + $urandom_range(3);
        if (kind >= 12) fmt_chunk(sz, tg, ch, rt, al, bt, $urandom_range(1) ? 3 : 1);
        if ($urandom_range(4) == 0) junk_chunk($urandom_range(5));
        dsz = ($urandom_range(5) == 0) ? $urandom_range(0, 3) : $urandom;
        if (kind < 94) data_head(dsz);
        if (kind >= 94 && kind < 97 && file_bytes.size() > 20)
            file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 1)];
        send_file(kind >= 94 || $urandom_range(9) == 0);
        if ($urandom_range(3) == 0)
        begin
            for (int i = 0; i < 3; i++) send_beat($urandom, 0, $urandom_range(1));
            idle_in();
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        sb = new();
        sb.clear();
        rst_n = 0; in_valid = 0; out_ready = 0; in_data = '0;
        send_idle = 0; recv_stall = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: good PCM, float, extensible, bad magic, bad sizes, huge skip, no fmt, short files
        riff_head(0); fmt_chunk(16, 1, 2, 44100, 4, 16, 0); data_head(1000); send_file(0);
        riff_head(0); fmt_chunk(18, 3, 8, 384000, 32, 32, 0); data_head(32'hFFFFFFFF);
        send_file(0);
        riff_head(0); fmt_chunk(40, rwhp_pkg::TAG_EXT, 1, 8000, 3, 24, 1); data_head(2);
        send_file(0);
        riff_head(1); send_file(0);
        riff_head(0); fmt_chunk(4097, 1, 1, 8000, 1, 8, 0);
        file_bytes = file_bytes[0:23]; send_file(0);
        riff_head(0); fmt_chunk(15, 1, 1, 8000, 1, 8, 0); send_file(0);
        riff_head(0); put32(32'h4C495354, 1); put32(32'hFFFFFFFF, 0);
        for (int i = 0; i < 6; i++) file_bytes.push_back($urandom);
        send_file(1);
        riff_head(0); data_head(0); send_file(0);
        file_bytes = {8'h52, 8'h49}; send_file(1);
        riff_head(0); fmt_chunk(16, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF,
                                16'hFFFF, 0);
        file_bytes = file_bytes[0:25]; send_file(1);
        drain();

        sent = 0;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 88; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 88; end
                3: begin send_idle = 20; recv_stall = 20; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            while (sent < 360 * (ph + 1))
            begin
                random_file();
                sent += file_bytes.size();
                if ($urandom_range(15) == 0) drain();
            end
        end
        drain();
        if (sb.errors == 0)
            $display("riff_wave_header_parser: match");
        else
            $display("riff_wave_header_parser: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
